/* hdl/dda_line_rasterizer_defines.svh */
// Assertion macros shared by the checkers of the line rasterizer.
// Each macro expands to one labeled concurrent assertion on the rising clock
// edge, disabled while the active-low reset is asserted.
`ifndef DDA_LINE_RASTERIZER_DEFINES_SVH
`define DDA_LINE_RASTERIZER_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define DLR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dda_line_rasterizer: assertion failed");

// Consequent starts in the cycle after the antecedent.
`define DLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dda_line_rasterizer: assertion failed");

`endif

/* hdl/dlr_pkg.sv */
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared constants, codes and controller/datapath interface types of the
// DDA line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package dlr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;

    // Screen coordinates and configuration registers have fixed widths.
    localparam int OUT_BITS      = 14;
    localparam int CFG_BITS      = 12;
    localparam int CFG_ADDR_BITS = 2;
    localparam int M_DATA_W      = ((2 * OUT_BITS + 7) / 8) * 8;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_CENTER_X = CFG_ADDR_BITS'(0);
    localparam logic [CFG_ADDR_BITS-1:0] CFG_CENTER_Y = CFG_ADDR_BITS'(1);

    localparam logic [CFG_BITS-1:0] CENTER_X_RESET = CFG_BITS'(399);
    localparam logic [CFG_BITS-1:0] CENTER_Y_RESET = CFG_BITS'(349);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef struct packed {
        logic load;    // take endpoints, register differences and start position
        logic prep;    // form magnitudes, step count and dividends
        logic iter;    // one restoring division step on both axes
        logic finish;  // signed increments, pixel count, line active
        logic emit;    // register one pixel and advance the position
    } dlr_cmd_t;

    typedef struct packed {
        logic active;
    } dlr_sts_t;

endpackage

`default_nettype wire

/* hdl/dlr_ctrl.sv */
// ----------------------------------------------------------------------------
// dlr_ctrl
// Controller of the line rasterizer: input handshake, division sequencing
// and the valid flag of the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dlr_ctrl #(
    parameter int NUM_W = dlr_pkg::COORD_BITS_DEF + dlr_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    input  wire logic               s_tuser,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    input  wire dlr_pkg::dlr_sts_t  sts,
    output dlr_pkg::dlr_cmd_t       cmd
);

    localparam int CNT_W = $clog2(NUM_W);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             valid_reg, valid_next;
    logic             accept;

    // The output register frees up in the same cycle its item is taken.
    assign s_tready = (state_reg == ST_IDLE) && (!valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = valid_reg;

    assign cmd.load   = accept && (s_tuser == dlr_pkg::OP_LOAD);
    assign cmd.emit   = accept && (s_tuser == dlr_pkg::OP_STEP) && sts.active;
    assign cmd.prep   = (state_reg == ST_PREP);
    assign cmd.iter   = (state_reg == ST_DIV);
    assign cmd.finish = (state_reg == ST_DONE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cnt_next   = CNT_W'(NUM_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.emit)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/dlr_dpath.sv */
// ----------------------------------------------------------------------------
// dlr_dpath
// Datapath of the line rasterizer: endpoint differences, a two-lane
// restoring divider for the increments, position accumulators, screen
// mapping and the origin registers.
// ----------------------------------------------------------------------------
`default_nettype none

module dlr_dpath #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire dlr_pkg::dlr_cmd_t                   cmd,
    output dlr_pkg::dlr_sts_t                        sts,
    input  wire logic signed [COORD_BITS-1:0]        start_x,
    input  wire logic signed [COORD_BITS-1:0]        start_y,
    input  wire logic signed [COORD_BITS-1:0]        end_x,
    input  wire logic signed [COORD_BITS-1:0]        end_y,
    input  wire logic                                cfg_wr,
    input  wire logic [dlr_pkg::CFG_ADDR_BITS-1:0]   cfg_index,
    input  wire logic [dlr_pkg::CFG_BITS-1:0]        cfg_data,
    output logic signed [dlr_pkg::OUT_BITS-1:0]      pixel_x,
    output logic signed [dlr_pkg::OUT_BITS-1:0]      pixel_y,
    output logic                                     last
);

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int NUM_W  = COORD_BITS + FRAC_BITS;
    localparam int ACC_W  = COORD_BITS + FRAC_BITS + 2;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int OUT_W  = dlr_pkg::OUT_BITS;
    localparam int CFG_W  = dlr_pkg::CFG_BITS;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

    // Lane 0 is the x axis, lane 1 the y axis.
    logic signed [COORD_BITS-1:0] start_c [2];
    logic signed [COORD_BITS-1:0] end_c   [2];

    logic signed [ACC_W-1:0]  acc_reg   [2];
    logic signed [ACC_W-1:0]  acc_next  [2];
    logic signed [ACC_W-1:0]  step_reg  [2];
    logic signed [ACC_W-1:0]  step_next [2];
    logic signed [DIFF_W-1:0] diff_reg  [2];
    logic signed [DIFF_W-1:0] diff_next [2];
    logic [NUM_W-1:0]         num_reg   [2];
    logic [NUM_W-1:0]         num_next  [2];
    logic [COORD_BITS-1:0]    rem_reg   [2];
    logic [COORD_BITS-1:0]    rem_next  [2];
    logic                     neg_reg   [2];
    logic                     neg_next  [2];

    logic [COORD_BITS-1:0]    steps_reg, steps_next;
    logic [COORD_BITS:0]      left_reg, left_next;
    logic                     active_reg, active_next;
    logic [CFG_W-1:0]         center_x_reg, center_x_next;
    logic [CFG_W-1:0]         center_y_reg, center_y_next;
    logic signed [OUT_W-1:0]  px_reg, px_next;
    logic signed [OUT_W-1:0]  py_reg, py_next;
    logic                     last_reg, last_next;

    logic [DIFF_W-1:0]        abs_c   [2];
    logic [COORD_BITS-1:0]    mag_c   [2];
    logic [COORD_BITS:0]      shift_c [2];
    logic [COORD_BITS:0]      trial_c [2];
    logic [Q_W-1:0]           quot_c  [2];
    logic signed [ACC_W-1:0]  rnd_c   [2];
    logic signed [ACC_W-1:0]  whole_c [2];
    logic [COORD_BITS-1:0]    steps_c;
    logic [OUT_W-1:0]         cx_ext, cy_ext;

    assign start_c[0] = start_x;
    assign start_c[1] = start_y;
    assign end_c[0]   = end_x;
    assign end_c[1]   = end_y;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            abs_c[i]   = diff_reg[i][DIFF_W-1] ? DIFF_W'(-diff_reg[i]) : DIFF_W'(diff_reg[i]);
            mag_c[i]   = abs_c[i][COORD_BITS-1:0];
            shift_c[i] = {rem_reg[i], num_reg[i][NUM_W-1]};
            trial_c[i] = shift_c[i] - {1'b0, steps_reg};
            quot_c[i]  = (steps_reg == '0) ? '0 : num_reg[i][Q_W-1:0];
            // Round half away from zero: negative values lose one before the floor.
            rnd_c[i]   = acc_reg[i] + HALF
                         - $signed({{(ACC_W-1){1'b0}}, acc_reg[i][ACC_W-1]});
            whole_c[i] = rnd_c[i] >>> FRAC_BITS;
        end
    end

    assign steps_c = (mag_c[0] > mag_c[1]) ? mag_c[0] : mag_c[1];
    assign cx_ext  = {{(OUT_W-CFG_W){1'b0}}, center_x_reg};
    assign cy_ext  = {{(OUT_W-CFG_W){1'b0}}, center_y_reg};

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            acc_next[i]  = acc_reg[i];
            step_next[i] = step_reg[i];
            diff_next[i] = diff_reg[i];
            num_next[i]  = num_reg[i];
            rem_next[i]  = rem_reg[i];
            neg_next[i]  = neg_reg[i];
            if (cmd.load)
            begin
                diff_next[i] = DIFF_W'(end_c[i]) - DIFF_W'(start_c[i]);
                acc_next[i]  = ACC_W'(start_c[i]) <<< FRAC_BITS;
            end
            if (cmd.prep)
            begin
                num_next[i] = (NUM_W'(mag_c[i]) << FRAC_BITS) + NUM_W'(steps_c >> 1);
                rem_next[i] = '0;
                neg_next[i] = diff_reg[i][DIFF_W-1];
            end
            if (cmd.iter)
            begin
                if (!trial_c[i][COORD_BITS])
                begin
                    rem_next[i] = trial_c[i][COORD_BITS-1:0];
                    num_next[i] = {num_reg[i][NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = shift_c[i][COORD_BITS-1:0];
                    num_next[i] = {num_reg[i][NUM_W-2:0], 1'b0};
                end
            end
            if (cmd.finish)
            begin
                step_next[i] = neg_reg[i] ? -$signed({{(ACC_W-Q_W){1'b0}}, quot_c[i]})
                                          :  $signed({{(ACC_W-Q_W){1'b0}}, quot_c[i]});
            end
            if (cmd.emit)
            begin
                acc_next[i] = acc_reg[i] + step_reg[i];
            end
        end
    end

    always_comb
    begin
        steps_next    = steps_reg;
        left_next     = left_reg;
        active_next   = active_reg;
        center_x_next = center_x_reg;
        center_y_next = center_y_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        last_next     = last_reg;
        if (cfg_wr && (cfg_index == dlr_pkg::CFG_CENTER_X))
        begin
            center_x_next = cfg_data;
        end
        if (cfg_wr && (cfg_index == dlr_pkg::CFG_CENTER_Y))
        begin
            center_y_next = cfg_data;
        end
        if (cmd.load)
        begin
            active_next = 1'b0;
        end
        if (cmd.prep)
        begin
            steps_next = steps_c;
        end
        if (cmd.finish)
        begin
            left_next   = {1'b0, steps_reg} + (COORD_BITS+1)'(1);
            active_next = 1'b1;
        end
        if (cmd.emit)
        begin
            px_next   = $signed(cx_ext + whole_c[0][OUT_W-1:0]);
            py_next   = $signed(cy_ext - whole_c[1][OUT_W-1:0]);
            last_next = (left_reg == (COORD_BITS+1)'(1));
            left_next = left_reg - (COORD_BITS+1)'(1);
            if (left_reg == (COORD_BITS+1)'(1))
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg     <= '0;
            active_reg   <= 1'b0;
            center_x_reg <= dlr_pkg::CENTER_X_RESET;
            center_y_reg <= dlr_pkg::CENTER_Y_RESET;
        end
        else
        begin
            left_reg     <= left_next;
            active_reg   <= active_next;
            center_x_reg <= center_x_next;
            center_y_reg <= center_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            acc_reg[i]  <= acc_next[i];
            step_reg[i] <= step_next[i];
            diff_reg[i] <= diff_next[i];
            num_reg[i]  <= num_next[i];
            rem_reg[i]  <= rem_next[i];
            neg_reg[i]  <= neg_next[i];
        end
        steps_reg <= steps_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        last_reg  <= last_next;
    end

    assign sts.active = active_reg;
    assign pixel_x    = px_reg;
    assign pixel_y    = py_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

/* hdl/dda_line_rasterizer.sv */
// A load item (tuser 0) takes two endpoints and computes the per-axis
// increments with a bit-serial restoring divider, one quotient bit per cycle
// on both axes at once; the input is then not ready until the increments are
// signed: the differences are registered as the load is taken, then the
// prep state forms the magnitudes and dividends, the divide state runs one
// restoring step per dividend bit and the done state signs the
// increments. Step items (tuser 1) are taken one per cycle while the block
// is idle and the output register can move, each giving one
// pixel with tlast on the final pixel of the line; a step item with no line
// active is taken and gives nothing. The origin registers are written through
// the cfg port, which is always ready and should be used while the block is
// idle.
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasterizer with fixed-point increments and screen mapping.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_line_rasterizer #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    // tdata: start_x, start_y, end_x, end_y (lowest bits first), zero padded
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]         s_tdata,
    // tuser: operation
    input  wire logic                                      s_tuser,
    input  wire logic                                      s_tvalid,
    output logic                                           s_tready,
    // tdata: pixel_x, pixel_y (lowest bits first), zero padded
    output logic [dlr_pkg::M_DATA_W-1:0]                   m_tdata,
    output logic                                           m_tlast,
    output logic                                           m_tvalid,
    input  wire logic                                      m_tready,
    input  wire logic                                      cfg_valid,
    output logic                                           cfg_ready,
    input  wire logic [dlr_pkg::CFG_ADDR_BITS-1:0]         cfg_index,
    input  wire logic [dlr_pkg::CFG_BITS-1:0]              cfg_data
);

    localparam int OUT_W = dlr_pkg::OUT_BITS;

    dlr_pkg::dlr_cmd_t       cmd;
    dlr_pkg::dlr_sts_t       sts;
    logic signed [OUT_W-1:0] pixel_x;
    logic signed [OUT_W-1:0] pixel_y;

    assign cfg_ready = 1'b1;

    dlr_ctrl #(
        .NUM_W (COORD_BITS + FRAC_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dlr_dpath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .start_x   ($signed(s_tdata[COORD_BITS-1:0])),
        .start_y   ($signed(s_tdata[2*COORD_BITS-1:COORD_BITS])),
        .end_x     ($signed(s_tdata[3*COORD_BITS-1:2*COORD_BITS])),
        .end_y     ($signed(s_tdata[4*COORD_BITS-1:3*COORD_BITS])),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .last      (m_tlast)
    );

    assign m_tdata = {{(dlr_pkg::M_DATA_W - 2*OUT_W){1'b0}}, pixel_y, pixel_x};

endmodule

`default_nettype wire

/* hdl/dlr_checker.sv */
// ----------------------------------------------------------------------------
// dlr_checker
// Port-level checks of the line rasterizer, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dda_line_rasterizer_defines.svh"

module dlr_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            s_tuser,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [dlr_pkg::M_DATA_W-1:0]    m_tdata,
    input wire logic                            m_tlast
);

    logic load_taken;
    logic step_taken;
    logic out_stall;

    assign load_taken = s_tvalid && s_tready && (s_tuser == dlr_pkg::OP_LOAD);
    assign step_taken = s_tvalid && s_tready && (s_tuser == dlr_pkg::OP_STEP);
    assign out_stall  = m_tvalid && !m_tready;

    // A stalled pixel stays put.
    `DLR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_tvalid && $stable({m_tdata, m_tlast}))

    // After a load item the input stays closed through the prep state and the first division step.
    `DLR_ASSERT_NEXT(a_load_busy, clk, rst_n, load_taken, !s_tready ##1 !s_tready)

    // A pixel appears only after a step item was taken.
    `DLR_ASSERT_SAME(a_out_cause, clk, rst_n, $rose(m_tvalid), $past(step_taken))

endmodule

bind dda_line_rasterizer dlr_checker u_dlr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
